@@ rtl/pidpd_pkg.sv @@
// Shared types, widths and codes for the PID position/delta controller.
// Used by pidpd_cfg, pidpd_calc and pid_position_delta_controller.
// No dependencies.
package pidpd_pkg;

	localparam int DATA_WIDTH     = 16;
	localparam int GAIN_W         = 16;
	localparam int GAIN_FRAC_BITS = 8;
	localparam int OUT_W          = 16;
	localparam int OLIM_W         = 15;
	localparam int ILIM_W         = 31;
	localparam int THR_W          = 16;
	localparam int ACC_W          = 32;
	localparam int CFG_DATA_W     = 31;
	localparam int CFG_INDEX_W    = 3;
	localparam int STATUS_W       = 2;

	localparam int ERR_W  = DATA_WIDTH + 1;
	localparam int D1_W   = ERR_W + 1;
	localparam int D2_W   = ERR_W + 2;
	localparam int ISUM_W = ACC_W + 1;
	localparam int SUM_W  = ACC_W + 3;

	localparam logic [CFG_INDEX_W-1:0] REG_GAIN_PROP    = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_GAIN_INTEG   = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_GAIN_DERIV   = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_LOOP_MODE    = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_LIMIT = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_INTEG_LIMIT  = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_ERROR_CUTOFF = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_DEAD_ZONE    = 3'd7;

	localparam logic MODE_POSITIONAL  = 1'b0;
	localparam logic MODE_INCREMENTAL = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_CUTOFF   = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_DEADZONE = 2'd2;

	localparam logic [OLIM_W-1:0] OUTPUT_LIMIT_RESET = 15'h7FFF;

	typedef struct packed {
		logic [GAIN_W-1:0] gain_prop;
		logic [GAIN_W-1:0] gain_integ;
		logic [GAIN_W-1:0] gain_deriv;
		logic              loop_mode;
		logic [OLIM_W-1:0] output_limit;
		logic [ILIM_W-1:0] integ_limit;
		logic [THR_W-1:0]  error_cutoff;
		logic [THR_W-1:0]  dead_zone;
	} cfg_t;

	typedef struct packed {
		logic [ERR_W-1:0] error_prev;
		logic [ERR_W-1:0] error_prev2;
		logic [ACC_W-1:0] integral_acc;
		logic [OUT_W-1:0] prev_output;
	} state_t;

	typedef struct packed {
		logic [OUT_W-1:0]    drive;
		logic [STATUS_W-1:0] status;
	} result_t;

endpackage

@@ rtl/pidpd_cfg.sv @@
// Configuration register file of the PID controller.
// Depends on pidpd_pkg for the register indexes and the cfg_t layout.
module pidpd_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wen,
	input  logic [pidpd_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [pidpd_pkg::CFG_DATA_W-1:0]     cfg_data,
	output pidpd_pkg::cfg_t                      cfg
);

	pidpd_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_prop    <= '0;
			cfg_q.gain_integ   <= '0;
			cfg_q.gain_deriv   <= '0;
			cfg_q.loop_mode    <= pidpd_pkg::MODE_POSITIONAL;
			cfg_q.output_limit <= pidpd_pkg::OUTPUT_LIMIT_RESET;
			cfg_q.integ_limit  <= '0;
			cfg_q.error_cutoff <= '0;
			cfg_q.dead_zone    <= '0;
		end else if (cfg_wen) begin
			case (cfg_index)
				pidpd_pkg::REG_GAIN_PROP: begin
					cfg_q.gain_prop <= cfg_data[pidpd_pkg::GAIN_W-1:0];
				end
				pidpd_pkg::REG_GAIN_INTEG: begin
					cfg_q.gain_integ <= cfg_data[pidpd_pkg::GAIN_W-1:0];
				end
				pidpd_pkg::REG_GAIN_DERIV: begin
					cfg_q.gain_deriv <= cfg_data[pidpd_pkg::GAIN_W-1:0];
				end
				pidpd_pkg::REG_LOOP_MODE: begin
					cfg_q.loop_mode <= cfg_data[0];
				end
				pidpd_pkg::REG_OUTPUT_LIMIT: begin
					cfg_q.output_limit <= cfg_data[pidpd_pkg::OLIM_W-1:0];
				end
				pidpd_pkg::REG_INTEG_LIMIT: begin
					cfg_q.integ_limit <= cfg_data[pidpd_pkg::ILIM_W-1:0];
				end
				pidpd_pkg::REG_ERROR_CUTOFF: begin
					cfg_q.error_cutoff <= cfg_data[pidpd_pkg::THR_W-1:0];
				end
				pidpd_pkg::REG_DEAD_ZONE: begin
					cfg_q.dead_zone <= cfg_data[pidpd_pkg::THR_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/pidpd_calc.sv @@
// Single-pass PID datapath: error, suppression tests, three gain products,
// integral clamp, output sum and saturation, and the next loop state.
// Depends on pidpd_pkg.
module pidpd_calc (
	input  logic [pidpd_pkg::DATA_WIDTH-1:0] measured,
	input  logic [pidpd_pkg::DATA_WIDTH-1:0] target,
	input  pidpd_pkg::cfg_t                  cfg,
	input  pidpd_pkg::state_t                state,
	output pidpd_pkg::result_t               result,
	output pidpd_pkg::state_t                state_next,
	output logic                             update
);

	localparam int ERR_W  = pidpd_pkg::ERR_W;
	localparam int D1_W   = pidpd_pkg::D1_W;
	localparam int D2_W   = pidpd_pkg::D2_W;
	localparam int GAIN_W = pidpd_pkg::GAIN_W;
	localparam int FRAC   = pidpd_pkg::GAIN_FRAC_BITS;
	localparam int ISUM_W = pidpd_pkg::ISUM_W;
	localparam int SUM_W  = pidpd_pkg::SUM_W;
	localparam int ACC_W  = pidpd_pkg::ACC_W;
	localparam int OUT_W  = pidpd_pkg::OUT_W;
	localparam int PP_W   = GAIN_W + D1_W;
	localparam int IP_W   = GAIN_W + ERR_W;
	localparam int DP_W   = GAIN_W + D2_W;

	logic signed [pidpd_pkg::DATA_WIDTH-1:0] meas_s, tgt_s;
	logic signed [ERR_W-1:0]  err, ep, ep2;
	logic        [ERR_W-1:0]  mag;
	logic signed [D1_W-1:0]   d1, p_x;
	logic signed [D2_W-1:0]   d2, d_x;
	logic signed [GAIN_W-1:0] kp, ki, kd;
	logic signed [PP_W-1:0]   p_prod;
	logic signed [IP_W-1:0]   i_prod;
	logic signed [DP_W-1:0]   d_prod;
	logic signed [PP_W-FRAC-1:0] p_term;
	logic signed [IP_W-FRAC-1:0] i_term;
	logic signed [DP_W-FRAC-1:0] d_term;
	logic                     incr;
	logic                     over_cutoff, in_dead;
	logic signed [ACC_W-1:0]  acc_base, acc_new;
	logic signed [ISUM_W-1:0] isum, ilim, ilim_neg;
	logic signed [OUT_W-1:0]  prev_s, prev_base, drive;
	logic signed [SUM_W-1:0]  sum, olim, olim_neg;

	always_comb begin
		meas_s = measured;
		tgt_s  = target;
		ep     = state.error_prev;
		ep2    = state.error_prev2;
		kp     = cfg.gain_prop;
		ki     = cfg.gain_integ;
		kd     = cfg.gain_deriv;
		incr   = (cfg.loop_mode == pidpd_pkg::MODE_INCREMENTAL);

		err = ERR_W'(tgt_s) - ERR_W'(meas_s);
		mag = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);

		over_cutoff = (cfg.error_cutoff != '0) && (mag > ERR_W'(cfg.error_cutoff));
		in_dead     = (cfg.dead_zone != '0) && (mag < ERR_W'(cfg.dead_zone));

		d1 = D1_W'(err) - D1_W'(ep);
		d2 = D2_W'(err) - (D2_W'(ep) <<< 1) + D2_W'(ep2);

		p_x = incr ? d1 : D1_W'(err);
		d_x = incr ? d2 : D2_W'(d1);

		p_prod = PP_W'(kp) * PP_W'(p_x);
		i_prod = IP_W'(ki) * IP_W'(err);
		d_prod = DP_W'(kd) * DP_W'(d_x);

		p_term = p_prod[PP_W-1:FRAC];
		i_term = i_prod[IP_W-1:FRAC];
		d_term = d_prod[DP_W-1:FRAC];

		acc_base = incr ? '0 : ACC_W'(state.integral_acc);
		isum     = ISUM_W'(acc_base) + ISUM_W'(i_term);
		ilim     = $signed({{(ISUM_W - pidpd_pkg::ILIM_W){1'b0}}, cfg.integ_limit});
		ilim_neg = -ilim;
		if (isum > ilim) begin
			acc_new = ACC_W'(ilim);
		end else if (isum < ilim_neg) begin
			acc_new = ACC_W'(ilim_neg);
		end else begin
			acc_new = ACC_W'(isum);
		end

		prev_s    = state.prev_output;
		prev_base = incr ? prev_s : '0;
		sum       = SUM_W'(prev_base) + SUM_W'(p_term) + SUM_W'(acc_new) + SUM_W'(d_term);
		olim      = $signed({{(SUM_W - pidpd_pkg::OLIM_W){1'b0}}, cfg.output_limit});
		olim_neg  = -olim;
		if (sum > olim) begin
			drive = OUT_W'(olim);
		end else if (sum < olim_neg) begin
			drive = OUT_W'(olim_neg);
		end else begin
			drive = OUT_W'(sum);
		end

		update = !over_cutoff && !in_dead;

		if (over_cutoff) begin
			result.drive  = '0;
			result.status = pidpd_pkg::STATUS_CUTOFF;
		end else if (in_dead) begin
			result.drive  = '0;
			result.status = pidpd_pkg::STATUS_DEADZONE;
		end else begin
			result.drive  = drive;
			result.status = pidpd_pkg::STATUS_OK;
		end

		state_next.error_prev   = err;
		state_next.error_prev2  = ep;
		state_next.integral_acc = acc_new;
		state_next.prev_output  = incr ? drive : prev_s;
	end

endmodule

@@ rtl/pid_position_delta_controller.sv @@
// PID controller, positional or incremental, top level.
// Instantiates pidpd_cfg and pidpd_calc; depends on pidpd_pkg.
//
// Usage:
//   Input beats on s_tvalid/s_tready/s_tdata carry a measured value and a
//   target. Each input beat yields exactly one output beat on
//   m_tvalid/m_tready/m_tdata/m_tuser: the saturated drive and a status code.
//   Registers are written through cfg_wen/cfg_index/cfg_data, one per cycle,
//   while no beat is in flight.
// Pipeline and throughput:
//   An accepted beat is held in the input register, passes the datapath and
//   lands in the output register, which drives m_tvalid. One beat per cycle is
//   sustained while m_tready stays high; the loop state updates as a beat moves
//   to the output register, unless the cutoff or dead zone suppresses it, so the
//   next beat sees it at once.
// Reset:
//   arst_n clears the loop state and both pipeline valids; all configuration
//   registers go to zero except output_limit, which resets to full scale.
// Stall:
//   While m_tready is low the output beat holds; one more beat waits in the
//   input register, then s_tready drops until the output drains.
module pid_position_delta_controller (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [2*pidpd_pkg::DATA_WIDTH-1:0]     s_tdata,  // measured, target
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [pidpd_pkg::OUT_W-1:0]            m_tdata,  // drive
	output logic [pidpd_pkg::STATUS_W-1:0]         m_tuser,  // status
	input  logic                                   cfg_wen,
	input  logic [pidpd_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [pidpd_pkg::CFG_DATA_W-1:0]       cfg_data
);

	localparam int DW = pidpd_pkg::DATA_WIDTH;

	pidpd_pkg::cfg_t    cfg;
	pidpd_pkg::state_t  state_q, state_next;
	pidpd_pkg::result_t result, result_s2;
	logic               update;
	logic               valid_s1, valid_s2;
	logic [DW-1:0]      measured_s1, target_s1;
	logic               advance;

	pidpd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pidpd_calc u_calc (
		.measured   (measured_s1),
		.target     (target_s1),
		.cfg        (cfg),
		.state      (state_q),
		.result     (result),
		.state_next (state_next),
		.update     (update)
	);

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			measured_s1 <= s_tdata[DW-1:0];
			target_s1   <= s_tdata[2*DW-1:DW];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance && update) begin
			state_q <= state_next;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = result_s2.drive;
	assign m_tuser  = result_s2.status;

endmodule

@@ test/pidpd_drive_checker.sv @@
// Drive checker for pid_position_delta_controller: watches the input, output and
// register-write channels, predicts every drive/status beat and compares in order.
// Depends on pidpd_pkg for widths, register indexes, mode and status codes.
module pidpd_drive_checker
	import pidpd_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	input  logic                        s_tready,
	input  logic [2*DATA_WIDTH-1:0]     s_tdata,  // measured, target
	input  logic                        m_tvalid,
	input  logic                        m_tready,
	input  logic [OUT_W-1:0]            m_tdata,  // drive
	input  logic [STATUS_W-1:0]         m_tuser,  // status
	input  logic                        cfg_wen,
	input  logic [CFG_INDEX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]       cfg_data,
	output int                          errors,
	output int                          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	longint gain_p, gain_i, gain_d;
	logic   loop_mode;
	longint out_lim, int_lim, cutoff, deadband;

	longint err_last, err_last2, integ_sum, last_drive;

	result_t expected_drives[$];

	function automatic longint gain_term(longint gain, longint x);
		return (gain * x) >>> GAIN_FRAC_BITS;
	endfunction

	function automatic longint sym_clamp(longint v, longint lim);
		if (v > lim)
			return lim;
		if (v < -lim)
			return -lim;
		return v;
	endfunction

	function automatic result_t predict_drive(logic [DATA_WIDTH-1:0] meas_raw,
	                                          logic [DATA_WIDTH-1:0] tgt_raw);
		shortint meas, tgt;
		longint  err, mag, drive;
		result_t r;
		meas = meas_raw;
		tgt  = tgt_raw;
		err  = longint'(tgt) - longint'(meas);
		mag  = (err < 0) ? -err : err;
		r.drive = '0;
		if (cutoff != 0 && mag > cutoff) begin
			r.status = STATUS_CUTOFF;
			return r;
		end
		if (deadband != 0 && mag < deadband) begin
			r.status = STATUS_DEADZONE;
			return r;
		end
		if (loop_mode == MODE_POSITIONAL) begin
			integ_sum = sym_clamp(integ_sum + gain_term(gain_i, err), int_lim);
			drive = gain_term(gain_p, err) + integ_sum + gain_term(gain_d, err - err_last);
			drive = sym_clamp(drive, out_lim);
		end else begin
			integ_sum = sym_clamp(gain_term(gain_i, err), int_lim);
			drive = last_drive + gain_term(gain_p, err - err_last) + integ_sum
			      + gain_term(gain_d, err - 2 * err_last + err_last2);
			drive = sym_clamp(drive, out_lim);
			last_drive = drive;
		end
		err_last2 = err_last;
		err_last  = err;
		r.drive  = drive[OUT_W-1:0];
		r.status = STATUS_OK;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			gain_p     = 0;
			gain_i     = 0;
			gain_d     = 0;
			loop_mode  = MODE_POSITIONAL;
			out_lim    = longint'(OUTPUT_LIMIT_RESET);
			int_lim    = 0;
			cutoff     = 0;
			deadband   = 0;
			err_last   = 0;
			err_last2  = 0;
			integ_sum  = 0;
			last_drive = 0;
			expected_drives.delete();
			errors     = 0;
			pending    = 0;
		end else begin
			if (cfg_wen) begin
				case (cfg_index)
					REG_GAIN_PROP:    gain_p    = longint'($signed(cfg_data[GAIN_W-1:0]));
					REG_GAIN_INTEG:   gain_i    = longint'($signed(cfg_data[GAIN_W-1:0]));
					REG_GAIN_DERIV:   gain_d    = longint'($signed(cfg_data[GAIN_W-1:0]));
					REG_LOOP_MODE:    loop_mode = cfg_data[0];
					REG_OUTPUT_LIMIT: out_lim   = longint'(cfg_data[OLIM_W-1:0]);
					REG_INTEG_LIMIT:  int_lim   = longint'(cfg_data[ILIM_W-1:0]);
					REG_ERROR_CUTOFF: cutoff    = longint'(cfg_data[THR_W-1:0]);
					REG_DEAD_ZONE:    deadband  = longint'(cfg_data[THR_W-1:0]);
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				expected_drives.push_back(predict_drive(s_tdata[DATA_WIDTH-1:0],
				                                        s_tdata[2*DATA_WIDTH-1:DATA_WIDTH]));
			if (m_tvalid && m_tready) begin
				if (expected_drives.size() == 0) begin
					$display("%0t: unexpected output beat, actual drive %h status %0d",
					         $time, m_tdata, m_tuser);
					errors++;
				end else begin
					want = expected_drives.pop_front();
					if (m_tdata !== want.drive) begin
						$display("%0t: drive mismatch, expected %h actual %h",
						         $time, want.drive, m_tdata);
						errors++;
					end
					if (m_tuser !== want.status) begin
						$display("%0t: status mismatch, expected %0d actual %0d",
						         $time, want.status, m_tuser);
						errors++;
					end
				end
			end
			pending = expected_drives.size();
		end
	end

endmodule

@@ test/pid_position_delta_controller_tb.sv @@
// Top of the pid_position_delta_controller testbench: clock, reset, register
// writes, bursty input stimulus and a stalling receiver; pidpd_drive_checker
// predicts and compares. Depends on pidpd_pkg and the RTL.
module pid_position_delta_controller_tb;
	import pidpd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT     = 200000;
	localparam int LONG_HOLD = 200;

	logic                    clk;
	logic                    arst_n;
	logic                    s_tvalid;
	logic                    s_tready;
	logic [2*DATA_WIDTH-1:0] s_tdata;
	logic                    m_tvalid;
	logic                    m_tready;
	logic [OUT_W-1:0]        m_tdata;
	logic [STATUS_W-1:0]     m_tuser;
	logic                    cfg_wen;
	logic [CFG_INDEX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0]   cfg_data;

	int errors;
	int pending;
	int cycle_count = 0;
	int burst_left  = 0;
	bit sender_steady = 1'b0;
	bit hold_req      = 1'b0;

	pid_position_delta_controller u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	pidpd_drive_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT) begin
			$display("[pid_position_delta_controller] ERROR");
			$finish;
		end
	end

	// receiver: random stall patterns plus one long hold-off on request
	initial begin
		int mode;
		int span;
		bit held;
		m_tready = 1'b1;
		span = 0;
		mode = 0;
		held = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !held) begin
				held = 1'b1;
				m_tready = 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
			end
			if (span == 0) begin
				mode = $urandom_range(0, 3);
				span = $urandom_range(10, 80);
			end
			span--;
			case (mode)
				0: m_tready = 1'b1;
				1: m_tready = $urandom_range(0, 1);
				2: m_tready = ($urandom_range(0, 3) == 0);
				default: m_tready = ~m_tready;
			endcase
		end
	end

	function automatic int pick_value(int lo, int hi, int tlo, int thi);
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return lo;
		if (r == 1)
			return hi;
		return tlo + int'($urandom_range(0, thi - tlo));
	endfunction

	task automatic send_beat(input logic [DATA_WIDTH-1:0] meas,
	                         input logic [DATA_WIDTH-1:0] tgt);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = (sender_steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_tvalid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_tdata  = {tgt, meas};
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic drain_results();
		s_tvalid = 1'b0;
		wait (pending == 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int val,
	                         input int width);
		logic [CFG_DATA_W-1:0] mask;
		mask = (CFG_DATA_W'(1) << width) - 1'b1;
		cfg_index = idx;
		cfg_data  = (CFG_DATA_W'($urandom()) & ~mask) | (CFG_DATA_W'(val) & mask);
		cfg_wen   = 1'b1;
		@(negedge clk);
		cfg_wen   = 1'b0;
	endtask

	task automatic randomize_setting();
		drain_results();
		write_reg(REG_GAIN_PROP, pick_value(-32768, 32767, -768, 768), GAIN_W);
		write_reg(REG_GAIN_INTEG, pick_value(-32768, 32767, -256, 256), GAIN_W);
		write_reg(REG_GAIN_DERIV, pick_value(-32768, 32767, -512, 512), GAIN_W);
		write_reg(REG_LOOP_MODE,
		          $urandom_range(0, 1) ? MODE_INCREMENTAL : MODE_POSITIONAL, 1);
		write_reg(REG_OUTPUT_LIMIT, pick_value(0, 32767, 100, 32767), OLIM_W);
		write_reg(REG_INTEG_LIMIT, pick_value(0, 2147483647, 0, 200000), ILIM_W);
		write_reg(REG_ERROR_CUTOFF,
		          $urandom_range(0, 1) ? 0 : pick_value(1, 65535, 50, 3000), THR_W);
		write_reg(REG_DEAD_ZONE,
		          $urandom_range(0, 2) ? 0 : pick_value(1, 65535, 1, 200), THR_W);
	endtask

	initial begin
		logic [DATA_WIDTH-1:0] meas;
		logic [DATA_WIDTH-1:0] tgt;
		int kind;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		cfg_wen   = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset gains: everything computes to zero
		send_beat(0, 0);
		send_beat(16'h8000, 16'h7FFF);
		send_beat(16'h7FFF, 16'h8000);
		drain_results();

		write_reg(REG_GAIN_PROP, 256, GAIN_W);
		write_reg(REG_GAIN_INTEG, 64, GAIN_W);
		write_reg(REG_GAIN_DERIV, -128, GAIN_W);
		write_reg(REG_LOOP_MODE, MODE_POSITIONAL, 1);
		write_reg(REG_OUTPUT_LIMIT, 32767, OLIM_W);
		write_reg(REG_INTEG_LIMIT, 1000, ILIM_W);
		write_reg(REG_ERROR_CUTOFF, 0, THR_W);
		write_reg(REG_DEAD_ZONE, 0, THR_W);
		send_beat(16'h8000, 16'h7FFF);
		send_beat(16'h7FFF, 16'h8000);
		send_beat(100, 90);
		send_beat(0, 0);
		send_beat(0, 0);
		drain_results();

		// cutoff and dead zone edges
		write_reg(REG_ERROR_CUTOFF, 100, THR_W);
		write_reg(REG_DEAD_ZONE, 10, THR_W);
		send_beat(0, 101);
		send_beat(0, DATA_WIDTH'(-101));
		send_beat(0, 100);
		send_beat(0, 5);
		send_beat(0, DATA_WIDTH'(-9));
		send_beat(0, 10);
		send_beat(0, DATA_WIDTH'(-100));
		drain_results();

		// cutoff takes precedence over the dead zone
		write_reg(REG_ERROR_CUTOFF, 5, THR_W);
		send_beat(0, 7);
		send_beat(0, 3);
		drain_results();

		// incremental mode with extreme gains, zero and full output limit
		write_reg(REG_ERROR_CUTOFF, 0, THR_W);
		write_reg(REG_DEAD_ZONE, 0, THR_W);
		write_reg(REG_LOOP_MODE, MODE_INCREMENTAL, 1);
		write_reg(REG_OUTPUT_LIMIT, 0, OLIM_W);
		write_reg(REG_GAIN_PROP, 32767, GAIN_W);
		write_reg(REG_GAIN_INTEG, -32768, GAIN_W);
		write_reg(REG_GAIN_DERIV, 32767, GAIN_W);
		write_reg(REG_INTEG_LIMIT, 2147483647, ILIM_W);
		send_beat(16'h8000, 16'h7FFF);
		send_beat(16'h7FFF, 16'h8000);
		drain_results();
		write_reg(REG_OUTPUT_LIMIT, 32767, OLIM_W);
		send_beat(16'h7FFF, 16'h8000);
		send_beat(16'h8000, 16'h7FFF);
		send_beat(0, 1);

		for (int ph = 0; ph < 10; ph++) begin
			randomize_setting();
			sender_steady = ($urandom_range(0, 3) == 0);
			if (ph == 0)
				hold_req = 1'b1;
			for (int n = 0; n < 50; n++) begin
				meas = DATA_WIDTH'($urandom());
				kind = $urandom_range(0, 9);
				if (kind < 7)
					tgt = meas + DATA_WIDTH'($urandom_range(0, 800)) - DATA_WIDTH'(400);
				else if (kind < 9)
					tgt = DATA_WIDTH'($urandom());
				else
					tgt = meas;
				send_beat(meas, tgt);
				if ($urandom_range(0, 79) == 0)
					drain_results();
			end
		end

		drain_results();
		repeat (8) @(negedge clk);
		if (errors == 0 && pending == 0)
			$display("[pid_position_delta_controller] OK");
		else
			$display("[pid_position_delta_controller] ERROR");
		$finish;
	end

endmodule
